// ===== rtl/tpcu_pkg.sv =====
// Shared constants, register codes and blend codes for the triangle pixel coverage unit.
package tpcu_pkg;

	localparam int PIX_BITS           = 12;
	localparam int COLOR_BITS         = 16;
	localparam int CFG_DATA_BITS      = 64;
	localparam int CFG_INDEX_BITS     = 3;
	localparam int COORD_BITS_DEF     = 13;
	localparam int CHANNEL_BITS_DEF   = 16;

	localparam int FILL_RED_LSB       = 3 * COLOR_BITS;
	localparam int FILL_GREEN_LSB     = 2 * COLOR_BITS;
	localparam int FILL_BLUE_LSB      = COLOR_BITS;
	localparam int FILL_ALPHA_LSB     = 0;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_VERTEX_A_X = 3'd0,
		REG_VERTEX_A_Y = 3'd1,
		REG_VERTEX_B_X = 3'd2,
		REG_VERTEX_B_Y = 3'd3,
		REG_VERTEX_C_X = 3'd4,
		REG_VERTEX_C_Y = 3'd5,
		REG_FILL_COLOR = 3'd6,
		REG_BLEND_MODE = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		BLEND_NORMAL = 1'b0,
		BLEND_SCREEN = 1'b1
	} blend_t;

endpackage

// ===== rtl/tpcu_if.sv =====
// Pixel input and pixel result channel interfaces.
interface tpcu_pix_in_if;
	import tpcu_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PIX_BITS-1:0]   pixel_x;
	logic [PIX_BITS-1:0]   pixel_y;
	logic [COLOR_BITS-1:0] old_red;
	logic [COLOR_BITS-1:0] old_green;
	logic [COLOR_BITS-1:0] old_blue;
	logic [COLOR_BITS-1:0] old_alpha;

	modport source (
		output valid, pixel_x, pixel_y, old_red, old_green, old_blue, old_alpha,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, old_red, old_green, old_blue, old_alpha,
		output ready
	);
endinterface

interface tpcu_pix_out_if;
	import tpcu_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PIX_BITS-1:0]   out_x;
	logic [PIX_BITS-1:0]   out_y;
	logic                  covered;
	logic                  write_enable;
	logic [COLOR_BITS-1:0] new_red;
	logic [COLOR_BITS-1:0] new_green;
	logic [COLOR_BITS-1:0] new_blue;
	logic [COLOR_BITS-1:0] new_alpha;

	modport source (
		output valid, out_x, out_y, covered, write_enable,
		       new_red, new_green, new_blue, new_alpha,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, covered, write_enable,
		       new_red, new_green, new_blue, new_alpha,
		output ready
	);
endinterface

// ===== rtl/triangle_pixel_coverage_unit.sv =====
// Triangle pixel coverage unit: area test of each pixel beat and fill colour selection.
// Each accepted beat is registered in the input stage, then in the result stage.
// Throughput: one pixel beat per cycle unless pix_out.ready stalls; the single compute
//   stage (six parallel edge multipliers, magnitude sum and compare) lies between input
//   and result registers. Vertex edges and the doubled area are registered from vertices.
// Reset clears both stage valid flags and all configuration registers to zero.
module triangle_pixel_coverage_unit #(
	parameter int COORD_BITS   = tpcu_pkg::COORD_BITS_DEF,
	parameter int CHANNEL_BITS = tpcu_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  tpcu_pkg::cfg_reg_t                   cfg_index,
	input  logic [tpcu_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	tpcu_pix_in_if.sink                          pix_in,
	tpcu_pix_out_if.source                       pix_out
);
	import tpcu_pkg::*;

	localparam int DW = ((COORD_BITS > PIX_BITS + 1) ? COORD_BITS : PIX_BITS + 1) + 1;
	localparam int PW = 2 * DW;
	localparam int AW = PW + 1;
	localparam int SW = AW + 2;
	localparam int CH = CHANNEL_BITS;

	function automatic logic [AW-1:0] area_mag(
		input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b,
		input logic signed [DW-1:0] c,
		input logic signed [DW-1:0] d
	);
		logic signed [PW-1:0] p0;
		logic signed [PW-1:0] p1;
		logic signed [AW-1:0] diff;
		p0   = PW'(a) * PW'(b);
		p1   = PW'(c) * PW'(d);
		diff = AW'(p0) - AW'(p1);
		return diff[AW-1] ? AW'(-diff) : AW'(diff);
	endfunction

	logic signed [COORD_BITS-1:0] va_x_q, va_y_q, vb_x_q, vb_y_q, vc_x_q, vc_y_q;
	logic [CH-1:0]                fill_r_q, fill_g_q, fill_b_q, fill_a_q;
	blend_t                       blend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_x_q   <= '0;
			va_y_q   <= '0;
			vb_x_q   <= '0;
			vb_y_q   <= '0;
			vc_x_q   <= '0;
			vc_y_q   <= '0;
			fill_r_q <= '0;
			fill_g_q <= '0;
			fill_b_q <= '0;
			fill_a_q <= '0;
			blend_q  <= BLEND_NORMAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VERTEX_A_X: va_x_q <= cfg_data[COORD_BITS-1:0];
				REG_VERTEX_A_Y: va_y_q <= cfg_data[COORD_BITS-1:0];
				REG_VERTEX_B_X: vb_x_q <= cfg_data[COORD_BITS-1:0];
				REG_VERTEX_B_Y: vb_y_q <= cfg_data[COORD_BITS-1:0];
				REG_VERTEX_C_X: vc_x_q <= cfg_data[COORD_BITS-1:0];
				REG_VERTEX_C_Y: vc_y_q <= cfg_data[COORD_BITS-1:0];
				REG_FILL_COLOR: begin
					fill_r_q <= cfg_data[FILL_RED_LSB +: CH];
					fill_g_q <= cfg_data[FILL_GREEN_LSB +: CH];
					fill_b_q <= cfg_data[FILL_BLUE_LSB +: CH];
					fill_a_q <= cfg_data[FILL_ALPHA_LSB +: CH];
				end
				REG_BLEND_MODE: blend_q <= blend_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	// Edge vectors between vertices and the doubled triangle area.
	logic signed [DW-1:0] e_bc_x, e_bc_y, e_ac_x, e_ac_y, e_ab_x, e_ab_y;
	logic signed [DW-1:0] e_bc_x_q, e_bc_y_q, e_ac_x_q, e_ac_y_q, e_ab_x_q, e_ab_y_q;
	logic [AW-1:0]        tri_area_q;

	always_comb begin
		e_bc_x = DW'(vb_x_q) - DW'(vc_x_q);
		e_bc_y = DW'(vb_y_q) - DW'(vc_y_q);
		e_ac_x = DW'(va_x_q) - DW'(vc_x_q);
		e_ac_y = DW'(va_y_q) - DW'(vc_y_q);
		e_ab_x = DW'(va_x_q) - DW'(vb_x_q);
		e_ab_y = DW'(va_y_q) - DW'(vb_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_bc_x_q   <= '0;
			e_bc_y_q   <= '0;
			e_ac_x_q   <= '0;
			e_ac_y_q   <= '0;
			e_ab_x_q   <= '0;
			e_ab_y_q   <= '0;
			tri_area_q <= '0;
		end else begin
			e_bc_x_q   <= e_bc_x;
			e_bc_y_q   <= e_bc_y;
			e_ac_x_q   <= e_ac_x;
			e_ac_y_q   <= e_ac_y;
			e_ab_x_q   <= e_ab_x;
			e_ab_y_q   <= e_ab_y;
			tri_area_q <= area_mag(e_ac_x, e_bc_y, e_ac_y, e_bc_x);
		end
	end

	// Handshake and stage advance.
	logic valid_s1, valid_s2;
	logic adv_s2, adv_s1;

	assign adv_s2       = !valid_s2 || pix_out.ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign pix_in.ready = adv_s1;

	// Input stage: pixel offsets from vertices C and B.
	logic [PIX_BITS-1:0]  x_s1, y_s1;
	logic signed [DW-1:0] dxc_s1, dyc_s1, dxb_s1, dyb_s1;
	logic [CH-1:0]        old_r_s1, old_g_s1, old_b_s1, old_a_s1;
	logic signed [DW-1:0] px_in, py_in;

	assign px_in = DW'($signed({1'b0, pix_in.pixel_x}));
	assign py_in = DW'($signed({1'b0, pix_in.pixel_y}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix_in.valid) begin
			x_s1     <= pix_in.pixel_x;
			y_s1     <= pix_in.pixel_y;
			dxc_s1   <= px_in - DW'(vc_x_q);
			dyc_s1   <= py_in - DW'(vc_y_q);
			dxb_s1   <= px_in - DW'(vb_x_q);
			dyb_s1   <= py_in - DW'(vb_y_q);
			old_r_s1 <= pix_in.old_red[CH-1:0];
			old_g_s1 <= pix_in.old_green[CH-1:0];
			old_b_s1 <= pix_in.old_blue[CH-1:0];
			old_a_s1 <= pix_in.old_alpha[CH-1:0];
		end
	end

	// Area test and fill decision.
	logic [AW-1:0] sub_bc, sub_ac, sub_ab;
	logic [SW-1:0] sub_sum;
	logic          covered_c, write_c;

	always_comb begin
		sub_bc    = area_mag(dxc_s1, e_bc_y_q, dyc_s1, e_bc_x_q);
		sub_ac    = area_mag(dxc_s1, e_ac_y_q, dyc_s1, e_ac_x_q);
		sub_ab    = area_mag(dxb_s1, e_ab_y_q, dyb_s1, e_ab_x_q);
		sub_sum   = SW'(sub_bc) + SW'(sub_ac) + SW'(sub_ab);
		covered_c = sub_sum <= SW'(tri_area_q);
		unique case (blend_q)
			BLEND_NORMAL: write_c = covered_c;
			BLEND_SCREEN: write_c = covered_c && (old_r_s1 < fill_r_q)
			                        && (old_g_s1 < fill_g_q) && (old_b_s1 < fill_b_q);
			default:      write_c = 1'b0;
		endcase
	end

	// Result stage.
	logic [PIX_BITS-1:0] x_s2, y_s2;
	logic                covered_s2, write_s2;
	logic [CH-1:0]       new_r_s2, new_g_s2, new_b_s2, new_a_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			x_s2       <= x_s1;
			y_s2       <= y_s1;
			covered_s2 <= covered_c;
			write_s2   <= write_c;
			new_r_s2   <= write_c ? fill_r_q : old_r_s1;
			new_g_s2   <= write_c ? fill_g_q : old_g_s1;
			new_b_s2   <= write_c ? fill_b_q : old_b_s1;
			new_a_s2   <= write_c ? fill_a_q : old_a_s1;
		end
	end

	assign pix_out.valid        = valid_s2;
	assign pix_out.out_x        = x_s2;
	assign pix_out.out_y        = y_s2;
	assign pix_out.covered      = covered_s2;
	assign pix_out.write_enable = write_s2;
	assign pix_out.new_red      = COLOR_BITS'(new_r_s2);
	assign pix_out.new_green    = COLOR_BITS'(new_g_s2);
	assign pix_out.new_blue     = COLOR_BITS'(new_b_s2);
	assign pix_out.new_alpha    = COLOR_BITS'(new_a_s2);

endmodule
